// File: rtl/thr_pkg.sv
package thr_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int TIME_BITS    = 48;
    localparam int OPCODE_BITS  = 2;
    localparam int CNT_BITS     = $clog2(DEPTH);
    localparam int FILL_BITS    = $clog2(DEPTH + 1);

    localparam logic [OPCODE_BITS-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_NEWEST = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic signed [TIME_BITS-1:0] stamp;
        logic [PAYLOAD_BITS-1:0]     payload;
    } thr_entry_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } thr_cell_ctrl_t;

endpackage

// File: rtl/thr_in_if.sv
interface thr_in_if;
    import thr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OPCODE_BITS-1:0]        opcode;
    logic signed [TIME_BITS-1:0]   time_stamp;
    logic [PAYLOAD_BITS-1:0]       payload;

    modport source (output valid, output opcode, output time_stamp, output payload,
                    input ready);
    modport sink (input valid, input opcode, input time_stamp, input payload,
                  output ready);
endinterface

// File: rtl/thr_out_if.sv
interface thr_out_if;
    import thr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic                    exact;
    logic [PAYLOAD_BITS-1:0] entry_payload;

    modport source (output valid, output hit, output exact, output entry_payload,
                    input ready);
    modport sink (input valid, input hit, input exact, input entry_payload,
                  output ready);
endinterface

// File: rtl/thr_cell.sv
module thr_cell (
    input  logic                   clk,
    input  thr_pkg::thr_cell_ctrl_t ctrl,
    input  thr_pkg::thr_entry_t    prev_entry,
    input  thr_pkg::thr_entry_t    next_entry,
    output thr_pkg::thr_entry_t    entry
);
    import thr_pkg::*;

    thr_entry_t entry_reg;
    thr_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = prev_entry;
        end
        else if (ctrl.rotate)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

// File: rtl/timestamped_history_ring_core.sv
// The history is a chain of DEPTH cells with the newest entry in the first cell. A push shifts
// the chain by one cell; a push, a clear and a newest query are each done as soon as taken. A
// lookup rotates the chain once round past a single signed comparator at the head, one cell per
// cycle, and no new word is taken until the scan has ended and its result has been registered; a
// lookup on an empty ring answers at once. A result waits in an output register, and a new word
// is taken only when that register is free or being emptied in the same cycle.
module timestamped_history_ring_core (
    input logic      clk,
    input logic      rst_n,
    thr_in_if.sink   cmd,
    thr_out_if.source res
);
    import thr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [FILL_BITS-1:0]    fill_reg, fill_next;
    logic signed [TIME_BITS-1:0] query_reg, query_next;
    logic                    found_reg, found_next;
    logic [PAYLOAD_BITS-1:0] found_pay_reg, found_pay_next;
    logic [PAYLOAD_BITS-1:0] oldest_pay_reg, oldest_pay_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic                    out_exact_reg, out_exact_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg, out_pay_next;

    thr_entry_t     cells [DEPTH];
    thr_entry_t     new_entry;
    thr_cell_ctrl_t cell_ctrl;
    logic           out_free;
    logic           accept;
    logic           head_valid;
    logic           head_match;

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign new_entry.stamp   = cmd.time_stamp;
    assign new_entry.payload = cmd.payload;

    assign cell_ctrl.shift  = accept && (cmd.opcode == OP_PUSH);
    assign cell_ctrl.rotate = (state_reg == ST_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % DEPTH;
            if (gi == 0)
            begin : g_head
                thr_cell u_cell (
                    .clk        (clk),
                    .ctrl       (cell_ctrl),
                    .prev_entry (new_entry),
                    .next_entry (cells[NXT]),
                    .entry      (cells[gi])
                );
            end
            else
            begin : g_body
                thr_cell u_cell (
                    .clk        (clk),
                    .ctrl       (cell_ctrl),
                    .prev_entry (cells[gi-1]),
                    .next_entry (cells[NXT]),
                    .entry      (cells[gi])
                );
            end
        end
    endgenerate

    assign head_valid = FILL_BITS'(cnt_reg) < fill_reg;
    assign head_match = head_valid && (cells[0].stamp <= query_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        query_next      = query_reg;
        found_next      = found_reg;
        found_pay_next  = found_pay_reg;
        oldest_pay_next = oldest_pay_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_hit_next    = out_hit_reg;
        out_exact_next  = out_exact_reg;
        out_pay_next    = out_pay_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        OP_PUSH:
                        begin
                            if (fill_reg < FILL_BITS'(DEPTH))
                            begin
                                fill_next = fill_reg + FILL_BITS'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        OP_NEWEST:
                        begin
                            out_valid_next = 1'b1;
                            out_hit_next   = (fill_reg != '0);
                            out_exact_next = 1'b0;
                            out_pay_next   = (fill_reg != '0) ? cells[0].payload : '0;
                        end
                        default:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_hit_next   = 1'b0;
                                out_exact_next = 1'b0;
                                out_pay_next   = '0;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                cnt_next   = '0;
                                query_next = cmd.time_stamp;
                                found_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (head_match && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_pay_next = cells[0].payload;
                end
                if (FILL_BITS'(cnt_reg) == fill_reg - FILL_BITS'(1))
                begin
                    oldest_pay_next = cells[0].payload;
                end
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b1;
                    out_exact_next = found_reg;
                    out_pay_next   = found_reg ? found_pay_reg : oldest_pay_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg      <= query_next;
        found_reg      <= found_next;
        found_pay_reg  <= found_pay_next;
        oldest_pay_reg <= oldest_pay_next;
        out_hit_reg    <= out_hit_next;
        out_exact_reg  <= out_exact_next;
        out_pay_reg    <= out_pay_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.hit           = out_hit_reg;
    assign res.exact         = out_exact_reg;
    assign res.entry_payload = out_pay_reg;

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (cnt_reg == CNT_BITS'(DEPTH - 1)) |=> (state_reg == ST_DONE))
        else $error("Lookup scan did not end after one full turn of the chain.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_BITS'(DEPTH))
        else $error("Fill count exceeds the ring depth.");

    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.opcode == OP_PUSH) && (fill_reg < FILL_BITS'(DEPTH))
        |=> (fill_reg == $past(fill_reg) + FILL_BITS'(1)))
        else $error("A push into a ring that is not full did not raise the fill count.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> !out_exact_reg && (out_pay_reg == '0))
        else $error("A miss carries a payload or the exact flag.");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.ready && !cell_ctrl.shift)
        else $error("A word was offered to the chain while a lookup was in progress.");
endmodule
